// File: rtl/core/tcw_pkg.sv
// tcw_pkg: shared constants, codes and controller/datapath interface types
// for the text console writer; no dependencies
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

    localparam int CELL_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int DATA_W = 16;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = 3;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] CR_CODE    = 8'd13;
    localparam logic [CHAR_W-1:0] LF_CODE    = 8'd10;

    // register word index (byte address bit 2)
    localparam logic REG_ATTR = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic load_in;
        logic write_put;
        logic read_cell;
        logic cap_read;
        logic col_zero;
        logic col_inc;
        logic row_inc;
        logic home;
        logic set_scrolled;
        logic sweep_start;
        logic addr_inc;
        logic write_blank;
        logic init_attr;
        logic copy_rd;
        logic copy_wr;
        logic out_load;
    } tcw_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  is_cr;
        logic  is_lf;
        logic  col_last;
        logic  row_last;
        logic  idx_ok;
        logic  addr_end_all;
        logic  addr_end_copy;
        logic  out_free;
    } tcw_status_t;

endpackage

// File: rtl/core/text_console_writer_unit.sv
// text_console_writer_unit: top level of the text console writer
// holds the attribute register and its register port; depends on tcw_pkg,
// tcw_ctrl and tcw_datapath
//
//  channel   handshake                   payload
//  input     in_valid / in_stall         kind, char_code, cell_index
//  output    out_valid / out_stall       read_data, cursor_row, cursor_col, scrolled
//  config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// put, carriage return, line feed, unused kind, out-of-range read: exec, then done
// in-range read: exec, read, then done
// scroll: alternating copy read and copy write states move each cell one row up,
// set by the single write and single read port of the screen memory; the last
// row is then blanked; clear: every cell is blanked; after reset a clearing pass
// runs before the first transaction is taken
// a finished result waits in the output register while out_stall is high
module text_console_writer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcw_pkg::KIND_W-1:0]    kind,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::DATA_W-1:0]    read_data,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     cursor_col,
    output logic                          scrolled,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic              attr_sel;
    tcw_cmd_t          cmd;
    tcw_status_t       status;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[2] == REG_ATTR) && (paddr[1:0] == 2'b00);
    assign prdata   = attr_sel ? {{(32 - ATTR_W){1'b0}}, attr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_ATTR))
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .attr       (attr_reg),
        .kind       (kind),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled)
    );

endmodule

// File: rtl/core/tcw_ctrl.sv
// tcw_ctrl: sequencing state machine of the text console writer
// depends on tcw_pkg; drives tcw_datapath through command and status structs
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_SCR_RD = 8'b0001_0000,
        S_SCR_WR = 8'b0010_0000,
        S_BLANK  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.write_blank = 1'b1;
                cmd.init_attr   = 1'b1;
                if (status.addr_end_all)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (status.kind)
                    KIND_PUT:
                    begin
                        if (status.is_cr)
                        begin
                            cmd.col_zero = 1'b1;
                        end
                        else if (status.is_lf)
                        begin
                            cmd.col_zero = 1'b1;
                            if (status.row_last)
                            begin
                                cmd.set_scrolled = 1'b1;
                                cmd.sweep_start  = 1'b1;
                                state_next       = S_SCR_RD;
                            end
                            else
                            begin
                                cmd.row_inc = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.write_put = 1'b1;
                            if (status.col_last)
                            begin
                                cmd.col_zero = 1'b1;
                                if (status.row_last)
                                begin
                                    cmd.set_scrolled = 1'b1;
                                    cmd.sweep_start  = 1'b1;
                                    state_next       = S_SCR_RD;
                                end
                                else
                                begin
                                    cmd.row_inc = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.col_inc = 1'b1;
                            end
                        end
                    end
                    KIND_READ:
                    begin
                        if (status.idx_ok)
                        begin
                            cmd.read_cell = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        cmd.home        = 1'b1;
                        cmd.sweep_start = 1'b1;
                        state_next      = S_BLANK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_DONE;
            end
            S_SCR_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                cmd.copy_wr  = 1'b1;
                cmd.addr_inc = 1'b1;
                if (status.addr_end_copy)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    state_next = S_SCR_RD;
                end
            end
            S_BLANK:
            begin
                cmd.write_blank = 1'b1;
                if (status.addr_end_all)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/tcw_datapath.sv
// tcw_datapath: screen memory, cursor, sweep address counter and result register
// depends on tcw_pkg; commanded by tcw_ctrl
module tcw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::tcw_cmd_t             cmd,
    output tcw_pkg::tcw_status_t          status,
    input  logic [tcw_pkg::ATTR_W-1:0]    attr,
    input  logic [tcw_pkg::KIND_W-1:0]    kind,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::DATA_W-1:0]    read_data,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     cursor_col,
    output logic                          scrolled
);
    import tcw_pkg::*;

    logic [DATA_W-1:0] screen_reg [CELLS];

    logic [KIND_W-1:0] kind_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CELL_W-1:0] addr_reg;
    logic [CELL_W-1:0] addr_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic              res_scrolled_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_scrolled_reg;

    logic [CELL_W-1:0] cursor_addr;
    logic [ATTR_W-1:0] blank_attr;
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [CELL_W-1:0] mem_raddr;

    assign cursor_addr = CELL_W'(row_reg) * CELL_W'(COLUMNS) + CELL_W'(col_reg);
    assign blank_attr  = cmd.init_attr ? RESET_ATTR : attr;

    // status
    assign status.kind          = kind_t'(kind_reg);
    assign status.is_cr         = (char_reg == CR_CODE);
    assign status.is_lf         = (char_reg == LF_CODE);
    assign status.col_last      = (col_reg == COL_W'(COLUMNS - 1));
    assign status.row_last      = (row_reg == ROW_W'(ROWS - 1));
    assign status.idx_ok        = (32'(idx_reg) < 32'(CELLS));
    assign status.addr_end_all  = (addr_reg == CELL_W'(CELLS - 1));
    assign status.addr_end_copy = (addr_reg == CELL_W'(COPY_LAST));
    assign status.out_free      = !out_valid_reg || !out_stall;

    // memory port select
    always_comb
    begin
        mem_we    = cmd.write_put || cmd.write_blank || cmd.copy_wr;
        mem_waddr = addr_reg;
        mem_wdata = rd_data_reg;
        if (cmd.write_put)
        begin
            mem_waddr = cursor_addr;
            mem_wdata = {attr, char_reg};
        end
        else if (cmd.write_blank)
        begin
            mem_wdata = {blank_attr, BLANK_CHAR};
        end
        mem_re    = cmd.read_cell || cmd.copy_rd;
        mem_raddr = cmd.read_cell ? CELL_W'(idx_reg) : addr_reg + CELL_W'(COLUMNS);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_reg[mem_raddr];
        end
    end

    // cursor, sweep counter, output handshake
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.home)
        begin
            row_next = '0;
            col_next = '0;
        end
        else
        begin
            if (cmd.row_inc)
            begin
                row_next = row_reg + 1'b1;
            end
            if (cmd.col_zero)
            begin
                col_next = '0;
            end
            else if (cmd.col_inc)
            begin
                col_next = col_reg + 1'b1;
            end
        end

        addr_next = addr_reg;
        if (cmd.sweep_start)
        begin
            addr_next = '0;
        end
        else if (cmd.addr_inc)
        begin
            addr_next = addr_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg         <= kind;
            char_reg         <= char_code;
            idx_reg          <= cell_index;
            res_data_reg     <= '0;
            res_scrolled_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cap_read)
            begin
                res_data_reg <= rd_data_reg;
            end
            if (cmd.set_scrolled)
            begin
                res_scrolled_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg     <= res_data_reg;
            out_row_reg      <= row_reg;
            out_col_reg      <= col_reg;
            out_scrolled_reg <= res_scrolled_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_data_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign scrolled   = out_scrolled_reg;

endmodule
